/* hdl/gravity_particle_step_top_defines.svh */
// Assertion macros for the gravity particle step block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef GRAVITY_PARTICLE_STEP_TOP_DEFINES_SVH
`define GRAVITY_PARTICLE_STEP_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gps_pkg.sv */
// Package for the gravity particle step block: widths, stream layout, codes and helpers.
// Used by gravity_particle_step_top; depends on nothing else.
package gps_pkg;

  localparam int unsigned MAX_PLANETS = 16;
  localparam int unsigned PIDX_W      = $clog2(MAX_PLANETS);
  localparam int unsigned CNT_W       = $clog2(MAX_PLANETS + 1);
  localparam int unsigned CFG_IDX_W   = 2;

  // Input beat layout, lowest bit first.
  localparam int unsigned IN_IDX_LSB   = 0;
  localparam int unsigned IN_PX_LSB    = IN_IDX_LSB + PIDX_W;
  localparam int unsigned IN_PY_LSB    = IN_PX_LSB + 32;
  localparam int unsigned IN_SIZE_LSB  = IN_PY_LSB + 32;
  localparam int unsigned IN_X_LSB     = IN_SIZE_LSB + 32;
  localparam int unsigned IN_Y_LSB     = IN_X_LSB + 32;
  localparam int unsigned IN_VX_LSB    = IN_Y_LSB + 32;
  localparam int unsigned IN_VY_LSB    = IN_VX_LSB + 32;
  localparam int unsigned IN_ACT_BIT   = IN_VY_LSB + 32;
  localparam int unsigned IN_TDATA_W   = ((IN_ACT_BIT + 1 + 7) / 8) * 8;

  localparam int unsigned OUT_FIELDS_W = 4 * 32 + 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [63:0] GRAV_NUM = 64'd2814749767106560000;
  localparam logic [47:0] G_CAP    = 48'h8000_0000_0000;

  typedef enum logic [0:0] {
    OP_SET_PLANET = 1'b0,
    OP_ADVANCE    = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP    = 2'd0,
    REG_PLANET_COUNT = 2'd1
  } reg_idx_e;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -49'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (32'd0 - v) : v;
    return r;
  endfunction

endpackage

/* hdl/gravity_particle_step_top.sv */
// Gravity particle step: planet table plus an iterative Euler integrator.
// Depends on gps_pkg and gravity_particle_step_top_defines.svh.
//
// Input stream (s_axis): tuser selects the operation. A set-planet beat writes one planet
// table entry (position, capture radius) and produces no result. An
// advance beat carries a particle; it produces exactly one result beat on m_axis.
// Configuration channel (cfg_*): always ready; index 0 sets dt, index 1 the planet count.
// Write it only while the block is idle.
// An inactive particle goes straight to the output register. An active one walks the
// planets in use: a planet at zero distance is skipped, any other one passes through the
// shared restoring divider (three 64-step quotients) and the 32-step square root; one
// 32x32 multiplier serves all products. A captured particle ends the planet walk early.
// s_axis_tready is high only while the sequencer is idle, so items are taken one at a
// time. The result sits in an output register: a stalled receiver holds it there, the
// next item may still be taken, and its result waits until the register is free.
// Reset clears the sequencer, the output valid, dt to 1.0 and the planet count to zero.
// Planet entries are undefined until written.
module gravity_particle_step_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // planet_index, planet_pos_x, planet_pos_y, planet_size, particle_x, particle_y,
  // speed_x, speed_y, particle_active, zero fill
  input  logic [gps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // new_x, new_y, new_speed_x, new_speed_y, captured, zero fill
  output logic [gps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  `include "gravity_particle_step_top_defines.svh"

  typedef enum logic [21:0] {
    ST_IDLE = 22'h000001,
    ST_LOAD = 22'h000002,
    ST_MXX  = 22'h000004,
    ST_MYY  = 22'h000008,
    ST_MRR  = 22'h000010,
    ST_SQI  = 22'h000020,
    ST_SQRT = 22'h000040,
    ST_DIVG = 22'h000080,
    ST_DIVX = 22'h000100,
    ST_DIVY = 22'h000200,
    ST_GX0  = 22'h000400,
    ST_GX1  = 22'h000800,
    ST_GX2  = 22'h001000,
    ST_GY1  = 22'h002000,
    ST_GY2  = 22'h004000,
    ST_CAPT = 22'h008000,
    ST_F0   = 22'h010000,
    ST_F1   = 22'h020000,
    ST_F2   = 22'h040000,
    ST_F3   = 22'h080000,
    ST_F4   = 22'h100000,
    ST_OUT  = 22'h200000
  } state_e;

  state_e state_q, state_d;
  logic ovalid_q, ovalid_d;
  logic [31:0] tstep_q, tstep_d;
  logic [gps_pkg::CNT_W-1:0] pcount_q, pcount_d, i_q, i_d, n_q, n_d;

  logic signed [31:0] px_q, px_d, py_q, py_d, vx_q, vx_d, vy_q, vy_d, fx_q, fx_d, fy_q, fy_d;
  logic cap_q, cap_d;
  logic signed [32:0] dx_q, dx_d, dy_q, dy_d;
  logic [31:0] ax_q, ax_d, ay_q, ay_d, rad_q, rad_d, s_q, s_d;
  logic [63:0] sq_q, sq_d, d2_q, d2_d, rr_q, rr_d, gm_q, gm_d, prod_q, prod_d;
  logic [47:0] g_q, g_d;
  logic [16:0] ux_q, ux_d, uy_q, uy_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d, dvd_q, dvd_d, dvs_q, dvs_d;
  logic [5:0] cnt_q, cnt_d;
  logic signed [31:0] ox_q, ox_d, oy_q, oy_d, ovx_q, ovx_d, ovy_q, ovy_d;
  logic ocap_q, ocap_d;

  logic [31:0] tab_x_q [gps_pkg::MAX_PLANETS];
  logic [31:0] tab_y_q [gps_pkg::MAX_PLANETS];
  logic [31:0] tab_r_q [gps_pkg::MAX_PLANETS];

  logic [31:0] mul_a, mul_b;
  logic        in_acc, tab_we;
  logic [gps_pkg::PIDX_W-1:0] in_idx;

  // Shared iterative-unit step values.
  logic [64:0] sqrt_t, div_r, div_sub;
  logic        sqrt_ge, div_ge;
  logic [63:0] sqrt_quo_nx, div_quo_nx;
  logic [63:0] gsum;
  logic [30:0] pull_m;
  logic signed [48:0] pull_v, dt_v;
  logic signed [32:0] dx_c, dy_c;
  logic [47:0] dt_m;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign tab_we        = in_acc && (s_axis_tuser == gps_pkg::OP_SET_PLANET);
  assign in_idx        = s_axis_tdata[gps_pkg::IN_IDX_LSB +: gps_pkg::PIDX_W];
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(gps_pkg::OUT_TDATA_W - gps_pkg::OUT_FIELDS_W){1'b0}},
                          ocap_q, ovy_q, ovx_q, oy_q, ox_q};

  assign sqrt_t      = {1'b0, quo_q} + {1'b0, dvs_q};
  assign sqrt_ge     = {1'b0, rem_q[63:0]} >= sqrt_t;
  assign sqrt_quo_nx = sqrt_ge ? ((quo_q >> 1) + dvs_q) : (quo_q >> 1);
  assign div_r       = {rem_q[63:0], dvd_q[63]};
  assign div_ge      = div_r >= {1'b0, dvs_q};
  assign div_sub     = div_r - {1'b0, dvs_q};
  assign div_quo_nx  = {quo_q[62:0], div_ge};

  // The high partial product of g*u is at most 2^31, so the 64-bit sum is exact.
  assign gsum   = gm_q + {prod_q[31:0], 32'd0};
  assign pull_m = (gsum[63:47] != 17'd0) ? 31'h7fff_ffff : gsum[46:16];
  assign dt_m   = prod_q[63:16];
  assign dt_v   = $signed({1'b0, dt_m});

  assign dx_c = $signed({px_q[31], px_q}) - $signed({tab_x_q[i_q[gps_pkg::PIDX_W-1:0]][31],
                                                     tab_x_q[i_q[gps_pkg::PIDX_W-1:0]]});
  assign dy_c = $signed({py_q[31], py_q}) - $signed({tab_y_q[i_q[gps_pkg::PIDX_W-1:0]][31],
                                                     tab_y_q[i_q[gps_pkg::PIDX_W-1:0]]});

  always_comb begin
    pull_v = $signed({18'd0, pull_m});
  end

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    tstep_d  = tstep_q;
    pcount_d = pcount_q;
    i_d = i_q;   n_d = n_q;
    px_d = px_q; py_d = py_q; vx_d = vx_q; vy_d = vy_q;
    fx_d = fx_q; fy_d = fy_q; cap_d = cap_q;
    dx_d = dx_q; dy_d = dy_q; ax_d = ax_q; ay_d = ay_q; rad_d = rad_q; s_d = s_q;
    sq_d = sq_q; d2_d = d2_q; rr_d = rr_q; gm_d = gm_q; g_d = g_q;
    ux_d = ux_q; uy_d = uy_q;
    rem_d = rem_q; quo_d = quo_q; dvd_d = dvd_q; dvs_d = dvs_q; cnt_d = cnt_q;
    ox_d = ox_q; oy_d = oy_q; ovx_d = ovx_q; ovy_d = ovy_q; ocap_d = ocap_q;
    mul_a = '0;
    mul_b = '0;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      if (cfg_index_i == gps_pkg::REG_TIME_STEP) begin
        tstep_d = cfg_data_i;
      end else if (cfg_index_i == gps_pkg::REG_PLANET_COUNT) begin
        pcount_d = cfg_data_i[gps_pkg::CNT_W-1:0];
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == gps_pkg::OP_ADVANCE)) begin
          px_d  = s_axis_tdata[gps_pkg::IN_X_LSB +: 32];
          py_d  = s_axis_tdata[gps_pkg::IN_Y_LSB +: 32];
          vx_d  = s_axis_tdata[gps_pkg::IN_VX_LSB +: 32];
          vy_d  = s_axis_tdata[gps_pkg::IN_VY_LSB +: 32];
          cap_d = 1'b0;
          fx_d  = '0;
          fy_d  = '0;
          i_d   = '0;
          n_d   = (pcount_q > gps_pkg::CNT_W'(gps_pkg::MAX_PLANETS)) ?
                  gps_pkg::CNT_W'(gps_pkg::MAX_PLANETS) : pcount_q;
          state_d = s_axis_tdata[gps_pkg::IN_ACT_BIT] ? ST_LOAD : ST_OUT;
        end
      end
      ST_LOAD: begin
        if (i_q == n_q) begin
          state_d = ST_F0;
        end else if (dx_c == '0 && dy_c == '0) begin
          i_d = i_q + 1'b1;
        end else begin
          dx_d  = dx_c;
          dy_d  = dy_c;
          ax_d  = dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
          ay_d  = dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
          rad_d = tab_r_q[i_q[gps_pkg::PIDX_W-1:0]];
          state_d = ST_MXX;
        end
      end
      ST_MXX: begin
        mul_a = ax_q; mul_b = ax_q;
        state_d = ST_MYY;
      end
      ST_MYY: begin
        mul_a = ay_q; mul_b = ay_q;
        sq_d  = prod_q;
        state_d = ST_MRR;
      end
      ST_MRR: begin
        mul_a = rad_q; mul_b = rad_q;
        d2_d  = ({1'b0, sq_q} + {1'b0, prod_q}) > 65'h0_ffff_ffff_ffff_ffff ?
                64'hffff_ffff_ffff_ffff : sq_q + prod_q;
        state_d = ST_SQI;
      end
      ST_SQI: begin
        rr_d  = prod_q;
        rem_d = {1'b0, d2_q};
        quo_d = '0;
        dvs_d = 64'h4000_0000_0000_0000;
        cnt_d = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        rem_d = sqrt_ge ? ({1'b0, rem_q[63:0]} - sqrt_t) : rem_q;
        quo_d = sqrt_quo_nx;
        dvs_d = dvs_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd31) begin
          s_d   = sqrt_quo_nx[31:0];
          rem_d = '0;
          quo_d = '0;
          dvd_d = gps_pkg::GRAV_NUM;
          dvs_d = d2_q;
          cnt_d = '0;
          state_d = ST_DIVG;
        end
      end
      ST_DIVG, ST_DIVX, ST_DIVY: begin
        rem_d = div_ge ? div_sub : div_r;
        quo_d = div_quo_nx;
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          rem_d = '0;
          quo_d = '0;
          dvs_d = {32'd0, s_q};
          if (state_q == ST_DIVG) begin
            g_d   = (div_quo_nx > {16'd0, gps_pkg::G_CAP}) ? gps_pkg::G_CAP :
                    div_quo_nx[47:0];
            dvd_d = {16'd0, ax_q, 16'd0};
            state_d = ST_DIVX;
          end else if (state_q == ST_DIVX) begin
            ux_d  = div_quo_nx[16:0];
            dvd_d = {16'd0, ay_q, 16'd0};
            state_d = ST_DIVY;
          end else begin
            uy_d  = div_quo_nx[16:0];
            state_d = ST_GX0;
          end
        end
      end
      ST_GX0: begin
        mul_a = g_q[31:0]; mul_b = {15'd0, ux_q};
        state_d = ST_GX1;
      end
      ST_GX1: begin
        mul_a = {16'd0, g_q[47:32]}; mul_b = {15'd0, ux_q};
        gm_d  = prod_q;
        state_d = ST_GX2;
      end
      ST_GX2: begin
        mul_a = g_q[31:0]; mul_b = {15'd0, uy_q};
        fx_d  = gps_pkg::sat32(49'(fx_q) + ((dx_q > 0) ? -pull_v : pull_v));
        state_d = ST_GY1;
      end
      ST_GY1: begin
        mul_a = {16'd0, g_q[47:32]}; mul_b = {15'd0, uy_q};
        gm_d  = prod_q;
        state_d = ST_GY2;
      end
      ST_GY2: begin
        fy_d  = gps_pkg::sat32(49'(fy_q) + ((dy_q > 0) ? -pull_v : pull_v));
        state_d = ST_CAPT;
      end
      ST_CAPT: begin
        // Inside the capture radius: motion stops and the remaining planets are skipped.
        if (d2_q < rr_q) begin
          fx_d = '0; fy_d = '0; vx_d = '0; vy_d = '0;
          cap_d = 1'b1;
          state_d = ST_F0;
        end else begin
          i_d = i_q + 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_F0: begin
        mul_a = gps_pkg::abs32(fx_q); mul_b = tstep_q;
        state_d = ST_F1;
      end
      ST_F1: begin
        mul_a = gps_pkg::abs32(fy_q); mul_b = tstep_q;
        vx_d  = gps_pkg::sat32(49'(vx_q) + (fx_q[31] ? -dt_v : dt_v));
        state_d = ST_F2;
      end
      ST_F2: begin
        mul_a = gps_pkg::abs32(vx_q); mul_b = tstep_q;
        vy_d  = gps_pkg::sat32(49'(vy_q) + (fy_q[31] ? -dt_v : dt_v));
        state_d = ST_F3;
      end
      ST_F3: begin
        mul_a = gps_pkg::abs32(vy_q); mul_b = tstep_q;
        px_d  = gps_pkg::sat32(49'(px_q) + (vx_q[31] ? -dt_v : dt_v));
        state_d = ST_F4;
      end
      ST_F4: begin
        py_d  = gps_pkg::sat32(49'(py_q) + (vy_q[31] ? -dt_v : dt_v));
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ox_d = px_q; oy_d = py_q; ovx_d = vx_q; ovy_d = vy_q; ocap_d = cap_q;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      tstep_q  <= 32'h0001_0000;
      pcount_q <= '0;
      i_q      <= '0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      tstep_q  <= tstep_d;
      pcount_q <= pcount_d;
      i_q      <= i_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d; py_q <= py_d; vx_q <= vx_d; vy_q <= vy_d;
    fx_q <= fx_d; fy_q <= fy_d; cap_q <= cap_d;
    dx_q <= dx_d; dy_q <= dy_d; ax_q <= ax_d; ay_q <= ay_d; rad_q <= rad_d; s_q <= s_d;
    sq_q <= sq_d; d2_q <= d2_d; rr_q <= rr_d; gm_q <= gm_d; g_q <= g_d; prod_q <= prod_d;
    ux_q <= ux_d; uy_q <= uy_d;
    rem_q <= rem_d; quo_q <= quo_d; dvd_q <= dvd_d; dvs_q <= dvs_d; cnt_q <= cnt_d;
    ox_q <= ox_d; oy_q <= oy_d; ovx_q <= ovx_d; ovy_q <= ovy_d; ocap_q <= ocap_d;
    if (tab_we) begin
      tab_x_q[in_idx] <= s_axis_tdata[gps_pkg::IN_PX_LSB +: 32];
      tab_y_q[in_idx] <= s_axis_tdata[gps_pkg::IN_PY_LSB +: 32];
      tab_r_q[in_idx] <= s_axis_tdata[gps_pkg::IN_SIZE_LSB +: 32];
    end
  end

  `GPS_ASSERT_IMP(a_cap_zero_speed, ovalid_q && ocap_q, ovx_q == '0 && ovy_q == '0,
    "captured result carries nonzero velocity")
  `GPS_ASSERT_IMP(a_planet_walk_bound, 1'b1, i_q <= n_q,
    "planet walk ran past the planet count")
  `GPS_ASSERT_NEXT(a_busy_after_advance,
    in_acc && (s_axis_tuser == gps_pkg::OP_ADVANCE), !s_axis_tready,
    "ready stayed high after an advance beat")

endmodule

/* tb/sv/gps_result_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the gravity particle step block: mirrors the planet table and registers,
// predicts each particle update and compares it with the output stream. Depends on gps_pkg.
module gps_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [gps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [gps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [gps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  output int                              pending_o,
  output int                              fail_count_o
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        cap;
  } particle_state_t;

  localparam longint unsigned PULL_NUM = 64'd2814749767106560000;
  localparam longint unsigned PULL_CAP = 64'h8000_0000_0000;

  logic [31:0] planet_x [gps_pkg::MAX_PLANETS];
  logic [31:0] planet_y [gps_pkg::MAX_PLANETS];
  logic [31:0] planet_r [gps_pkg::MAX_PLANETS];
  logic [31:0] dt_q;
  logic [4:0]  count_q;
  particle_state_t expected_q [$];
  int fails;

  assign pending_o    = expected_q.size();
  assign fail_count_o = fails;

  function automatic longint clamp32(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    longint unsigned r;
    r = (v < 0) ? (64'd0 - longint'(v)) : v;
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Signed value times unsigned Q16.16 dt, truncated toward zero.
  function automatic longint scale_dt(input longint a, input logic [31:0] t);
    longint unsigned m;
    m = (magnitude(a) * longint'({32'd0, t})) >> 16;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  // One force component: magnitude g times the unit component, pointing toward the planet.
  function automatic longint pull_part(input longint unsigned g, input longint d,
                                       input longint unsigned s);
    longint unsigned u, m;
    u = (magnitude(d) << 16) / s;
    m = (g * u) >> 16;
    if (m > 64'd2147483647) m = 64'd2147483647;
    return (d > 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic particle_state_t advance_particle(input logic [31:0] x, y, sx, sy,
                                                       input logic act);
    particle_state_t res;
    longint px, py, vx, vy, fx, fy, dx, dy;
    longint unsigned ax, ay, sq, d2, s, g, r;
    int n;
    px = longint'($signed(x));
    py = longint'($signed(y));
    vx = longint'($signed(sx));
    vy = longint'($signed(sy));
    fx = 0;
    fy = 0;
    res.cap = 1'b0;
    if (act) begin
      n = (count_q > gps_pkg::MAX_PLANETS) ? gps_pkg::MAX_PLANETS : count_q;
      for (int i = 0; i < n; i++) begin
        dx = px - longint'($signed(planet_x[i]));
        dy = py - longint'($signed(planet_y[i]));
        if (dx == 0 && dy == 0) continue;
        ax = magnitude(dx);
        ay = magnitude(dy);
        sq = ax * ax;
        d2 = sq + ay * ay;
        if (d2 < sq) d2 = 64'hFFFF_FFFF_FFFF_FFFF;
        s = int_sqrt(d2);
        g = PULL_NUM / d2;
        if (g > PULL_CAP) g = PULL_CAP;
        fx = clamp32(fx + pull_part(g, dx, s));
        fy = clamp32(fy + pull_part(g, dy, s));
        r = {32'd0, planet_r[i]};
        if (d2 < r * r) begin
          fx = 0;
          fy = 0;
          vx = 0;
          vy = 0;
          res.cap = 1'b1;
          break;
        end
      end
      vx = clamp32(vx + scale_dt(fx, dt_q));
      vy = clamp32(vy + scale_dt(fy, dt_q));
      px = clamp32(px + scale_dt(vx, dt_q));
      py = clamp32(py + scale_dt(vy, dt_q));
    end
    res.x  = px[31:0];
    res.y  = py[31:0];
    res.vx = vx[31:0];
    res.vy = vy[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    particle_state_t want, got;
    logic [gps_pkg::PIDX_W-1:0] idx;
    if (!rst_ni) begin
      dt_q    <= 32'h0001_0000;
      count_q <= '0;
      expected_q.delete();
      fails = 0;
      for (int i = 0; i < gps_pkg::MAX_PLANETS; i++) begin
        planet_x[i] = '0;
        planet_y[i] = '0;
        planet_r[i] = '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (gps_pkg::reg_idx_e'(cfg_index_i))
          gps_pkg::REG_TIME_STEP:    dt_q    <= cfg_data_i;
          gps_pkg::REG_PLANET_COUNT: count_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (gps_pkg::op_e'(s_axis_tuser) == gps_pkg::OP_SET_PLANET) begin
          idx = s_axis_tdata[gps_pkg::IN_IDX_LSB +: gps_pkg::PIDX_W];
          planet_x[idx] = s_axis_tdata[gps_pkg::IN_PX_LSB +: 32];
          planet_y[idx] = s_axis_tdata[gps_pkg::IN_PY_LSB +: 32];
          planet_r[idx] = s_axis_tdata[gps_pkg::IN_SIZE_LSB +: 32];
        end else begin
          expected_q.push_back(advance_particle(s_axis_tdata[gps_pkg::IN_X_LSB +: 32],
                                                s_axis_tdata[gps_pkg::IN_Y_LSB +: 32],
                                                s_axis_tdata[gps_pkg::IN_VX_LSB +: 32],
                                                s_axis_tdata[gps_pkg::IN_VY_LSB +: 32],
                                                s_axis_tdata[gps_pkg::IN_ACT_BIT]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x   = m_axis_tdata[31:0];
        got.y   = m_axis_tdata[63:32];
        got.vx  = m_axis_tdata[95:64];
        got.vy  = m_axis_tdata[127:96];
        got.cap = m_axis_tdata[128];
        if (expected_q.size() == 0) begin
          $error("result beat with no particle pending");
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.x !== want.x) begin
            $error("new_x: expected %h, got %h", want.x, got.x);
            fails++;
          end
          if (got.y !== want.y) begin
            $error("new_y: expected %h, got %h", want.y, got.y);
            fails++;
          end
          if (got.vx !== want.vx) begin
            $error("new_speed_x: expected %h, got %h", want.vx, got.vx);
            fails++;
          end
          if (got.vy !== want.vy) begin
            $error("new_speed_y: expected %h, got %h", want.vy, got.vy);
            fails++;
          end
          if (got.cap !== want.cap) begin
            $error("captured: expected %b, got %b", want.cap, got.cap);
            fails++;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_gravity_particle_step_top.sv */
`timescale 1ns / 100ps
// Testbench top for gravity_particle_step_top: drives planet and particle beats, register
// writes and output stalls; gps_result_checker does the prediction and comparison.
module tb_gravity_particle_step_top;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [gps_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]                      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [gps_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [gps_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [31:0]                     cfg_data_i;
  int                              pending;
  int                              fail_count;

  logic [31:0] known_px [gps_pkg::MAX_PLANETS];
  logic [31:0] known_py [gps_pkg::MAX_PLANETS];
  int  burst_left;
  int  items_sent;
  bit  hold_off_req;
  bit  hold_done;

  gravity_particle_step_top DUT (.*);

  gps_result_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall pattern drawn from four random modes; one long hold-off on request.
  initial begin
    int mode;
    int cyc;
    m_axis_tready = 1'b0;
    mode = 0;
    cyc  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (cyc % 256 == 0) mode = $urandom_range(0, 3);
        cyc++;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_beat(input gps_pkg::op_e op,
                           input logic [gps_pkg::IN_TDATA_W-1:0] data);
    int gap;
    bit rdy;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_planet(input logic [3:0] idx, input logic [31:0] x, y, size);
    logic [gps_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[gps_pkg::IN_IDX_LSB +: gps_pkg::PIDX_W] = idx;
    d[gps_pkg::IN_PX_LSB +: 32]               = x;
    d[gps_pkg::IN_PY_LSB +: 32]               = y;
    d[gps_pkg::IN_SIZE_LSB +: 32]             = size;
    // Two unused particle fields (x and speed_y) still carry random bits.
    d[gps_pkg::IN_X_LSB +: 32]                = $urandom;
    d[gps_pkg::IN_VY_LSB +: 32]               = $urandom;
    known_px[idx] = x;
    known_py[idx] = y;
    send_beat(gps_pkg::OP_SET_PLANET, d);
  endtask

  task automatic send_particle(input logic [31:0] x, y, vx, vy, input logic act);
    logic [gps_pkg::IN_TDATA_W-1:0] d;
    logic [31:0] rnd;
    d   = '0;
    rnd = $urandom;
    d[gps_pkg::IN_IDX_LSB +: gps_pkg::PIDX_W] = rnd[gps_pkg::PIDX_W-1:0];
    d[gps_pkg::IN_PX_LSB +: 32]               = $urandom;
    d[gps_pkg::IN_X_LSB +: 32]                = x;
    d[gps_pkg::IN_Y_LSB +: 32]                = y;
    d[gps_pkg::IN_VX_LSB +: 32]               = vx;
    d[gps_pkg::IN_VY_LSB +: 32]               = vy;
    d[gps_pkg::IN_ACT_BIT]                    = act;
    send_beat(gps_pkg::OP_ADVANCE, d);
  endtask

  // Stops offering beats until every result is back, then lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk_i);
      #1;
    end while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input gps_pkg::reg_idx_e idx, input logic [31:0] data);
    bit rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic set_regs(input logic [31:0] dt, input logic [31:0] cnt);
    write_reg(gps_pkg::REG_TIME_STEP, dt);
    write_reg(gps_pkg::REG_PLANET_COUNT, cnt);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: v = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
    return v;
  endfunction

  task automatic random_item();
    int k;
    logic [31:0] x, y;
    if ($urandom_range(0, 9) < 3) begin
      send_planet(4'($urandom), pick_coord(), pick_coord(),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0003_0000));
    end else begin
      k = $urandom_range(0, 15);
      case ($urandom_range(0, 3))
        0: begin
          x = pick_coord();
          y = pick_coord();
        end
        1: begin
          x = known_px[k];
          y = known_py[k];
        end
        default: begin
          x = known_px[k] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
          y = known_py[k] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        end
      endcase
      send_particle(x, y,
                    $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000) - 32'h20000,
                    $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000) - 32'h20000,
                    $urandom_range(0, 7) != 0);
    end
  endtask

  initial begin
    logic [31:0] dt_pick;
    int cnt_pick;
    int phase_len;
    int phase;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = gps_pkg::OP_SET_PLANET;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = gps_pkg::REG_TIME_STEP;
    cfg_data_i    = '0;
    hold_off_req  = 1'b0;
    hold_done     = 1'b0;
    burst_left    = 0;
    items_sent    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every table entry is written before any particle can read it.
    for (int i = 0; i < gps_pkg::MAX_PLANETS; i++) begin
      send_planet(4'(i), 32'h0010_0000 * 32'(i) - 32'h0080_0000, 32'h0008_0000 * 32'(i),
                  32'h0000_8000);
    end
    send_particle(32'h0001_0000, 32'h0002_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_particle(32'h7fff_ffff, 32'h8000_0000, 32'h0000_1000, 32'hffff_f000, 1'b1);
    drain();
    set_regs(32'h0001_0000, 32'd2);
    send_planet(4'd15, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_particle(32'hff80_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1);
    send_particle(32'hff80_8000, 32'h0000_4000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_particle(32'hff70_0000, 32'h0008_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_particle(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_particle(32'hff80_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();
    set_regs(32'hffff_ffff, 32'(gps_pkg::MAX_PLANETS));
    send_particle(32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_particle(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1);
    drain();
    set_regs(32'h0000_0000, 32'd1);
    send_particle(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();

    phase = 0;
    while (items_sent < 950) begin
      case ($urandom_range(0, 6))
        0:       dt_pick = 32'h0000_0000;
        1:       dt_pick = 32'hffff_ffff;
        2:       dt_pick = 32'h0001_0000;
        3:       dt_pick = $urandom;
        default: dt_pick = $urandom_range(1, 32'h0004_0000);
      endcase
      cnt_pick = ($urandom_range(0, 9) == 0) ? gps_pkg::MAX_PLANETS : $urandom_range(0, 3);
      set_regs(dt_pick, 32'(cnt_pick));
      phase_len = (cnt_pick > 4) ? 15 : 80;
      if (phase == 1) hold_off_req = 1'b1;
      repeat (phase_len) random_item();
      drain();
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
